// ----- rtl/core/srt_pkg.sv -----
// Package for the sorted range table: field widths, codes and word types.
// Used by sorted_range_table_core; depends on nothing else.
package srt_pkg;

  localparam int unsigned AddrW        = 47;
  localparam int unsigned EndW         = 48;
  localparam int unsigned LenW         = 32;
  localparam int unsigned HandleW      = 16;
  localparam int unsigned CountW       = 9;
  localparam int unsigned TableDepthDef = 256;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_MISS      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PLACE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [AddrW-1:0]   addr;
    logic [LenW-1:0]    length;
    logic [HandleW-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic               hit;
    logic [HandleW-1:0] found_handle;
    logic [CountW-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [AddrW-1:0]   start;
    logic [EndW-1:0]    stop;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

// ----- rtl/core/sorted_range_table_core.sv -----
// Sorted range table: binary search over one synchronous entry memory,
// with shift-up insert and shift-down remove. Depends on srt_pkg.
//
//   channel   direction  ports                 handshake
//   request   in         start, busy, req_i    taken when start high, busy low
//   response  out        done_o, rsp_o         one-cycle strobe, no back-pressure
//
// A lookup does one memory read per search step, one read of the candidate
// entry, then answers. Off-bounds lookups, lookup or remove on an empty table,
// op code 3 and a full-table insert answer straight from idle. Insert and
// remove shift entries with one read and one write each; insert then writes
// the new range at the insert point. busy holds the next word off until the
// answer strobes. Reset idles, zeroes count, high bound and done, sets low to ones.
module sorted_range_table_core
  import srt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // Entry memory
  entry_t            table_mem [TABLE_DEPTH];
  entry_t            rdata_q;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  // Control and working registers
  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [AddrW-1:0]  low_q, low_d;
  logic [EndW-1:0]   high_q, high_d;
  req_t              req_q, req_d;
  logic [EndW-1:0]   end_q, end_d;
  logic [CntW-1:0]   lo_q, lo_d;
  logic [CntW-1:0]   hi_q, hi_d;
  logic [IdxW-1:0]   mid_q, mid_d;
  logic [CntW-1:0]   ub_q, ub_d;
  logic [IdxW-1:0]   ptr_q, ptr_d;
  logic              done_q, done_d;
  rsp_t              rsp_q, rsp_d;

  // Shared terms
  logic              accept;
  logic              in_bounds;
  logic              table_full;
  logic [EndW-1:0]   new_end;
  logic [CntW:0]     mid0_sum;
  logic              rd_le;
  logic [CntW-1:0]   lo_n, hi_n;
  logic [CntW:0]     mid_sum;
  logic              more;
  logic [CntW-1:0]   ub_dec;
  logic [CntW-1:0]   cnt_dec;
  logic [IdxW-1:0]   ptr_inc;
  logic              up_more;
  logic              dn_start;
  logic              dn_more;
  logic              lookup_hit;
  logic              handle_match;

  assign busy       = (state_q != S_IDLE);
  assign accept     = start && !busy;
  assign in_bounds  = (req_i.addr >= low_q) && ({1'b0, req_i.addr} < high_q);
  assign table_full = (cnt_q == CntW'(TABLE_DEPTH));
  assign new_end    = {1'b0, req_i.addr} + EndW'(req_i.length);
  assign mid0_sum   = {1'b0, cnt_q};

  // One search step: narrow [lo, hi) by the entry read at mid
  assign rd_le    = (rdata_q.start <= req_q.addr);
  assign lo_n     = rd_le ? (CntW'(mid_q) + CntW'(1)) : lo_q;
  assign hi_n     = rd_le ? hi_q : CntW'(mid_q);
  assign mid_sum  = {1'b0, lo_n} + {1'b0, hi_n};
  assign more     = (lo_n < hi_n);
  assign ub_dec   = lo_n - CntW'(1);
  assign cnt_dec  = cnt_q - CntW'(1);
  assign ptr_inc  = ptr_q + 1'b1;

  assign up_more      = (CntW'(ptr_q) > ub_q);
  assign dn_start     = ((CntW'(ptr_q) + CntW'(1)) < cnt_q);
  assign dn_more      = ((CntW'(ptr_q) + CntW'(2)) < cnt_q);
  assign lookup_hit   = ({1'b0, req_q.addr} < rdata_q.stop);
  assign handle_match = (rdata_q.handle == req_q.handle);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority case (req_i.op)
            OP_LOOKUP: if (in_bounds && cnt_q != '0) state_d = S_SEARCH;
            OP_INSERT: begin
              if (!table_full) state_d = (cnt_q != '0) ? S_SEARCH : S_PLACE;
            end
            OP_REMOVE: if (cnt_q != '0) state_d = S_SEARCH;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SEARCH: begin
        if (!more) begin
          if (req_q.op == OP_INSERT) begin
            state_d = (cnt_q > lo_n) ? S_SHIFT_UP : S_PLACE;
          end else begin
            state_d = (lo_n != '0) ? S_CHECK : S_IDLE;
          end
        end
      end
      S_CHECK: begin
        if (req_q.op == OP_REMOVE && handle_match && dn_start) state_d = S_SHIFT_DN;
        else state_d = S_IDLE;
      end
      S_SHIFT_UP: if (!up_more) state_d = S_PLACE;
      S_SHIFT_DN: if (!dn_more) state_d = S_IDLE;
      S_PLACE:    state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath, memory access and response
  always_comb begin
    cnt_d     = cnt_q;
    low_d     = low_q;
    high_d    = high_q;
    req_d     = req_q;
    end_d     = end_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    ub_d      = ub_q;
    ptr_d     = ptr_q;
    mem_re    = 1'b0;
    mem_raddr = mid_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = rdata_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d     = req_i;
          end_d     = new_end;
          lo_d      = '0;
          hi_d      = cnt_q;
          mid_d     = mid0_sum[IdxW:1];
          mem_raddr = mid0_sum[IdxW:1];
          mem_re    = 1'b1;
          ub_d      = '0;
          // Answer at once where no search is needed
          rsp_d.hit          = 1'b0;
          rsp_d.found_handle = '0;
          rsp_d.entry_count  = CountW'(cnt_q);
          priority case (req_i.op)
            OP_LOOKUP: begin
              if (!(in_bounds && cnt_q != '0)) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_MISS;
              end
            end
            OP_INSERT: begin
              if (table_full) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_FULL;
              end else begin
                if (req_i.addr < low_q) low_d = req_i.addr;
                if (new_end > high_q) high_d = new_end;
              end
            end
            OP_REMOVE: begin
              if (cnt_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_NOT_FOUND;
              end
            end
            default: begin
              done_d       = 1'b1;
              rsp_d.status = STAT_OK;
            end
          endcase
        end
      end

      S_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        ub_d = lo_n;
        if (more) begin
          mid_d     = mid_sum[IdxW:1];
          mem_raddr = mid_sum[IdxW:1];
          mem_re    = 1'b1;
        end else if (req_q.op == OP_INSERT) begin
          // Start shifting from the last entry down to the insert point
          ptr_d     = cnt_dec[IdxW-1:0];
          mem_raddr = cnt_dec[IdxW-1:0];
          mem_re    = (cnt_q > lo_n);
        end else if (lo_n != '0) begin
          ptr_d     = ub_dec[IdxW-1:0];
          mem_raddr = ub_dec[IdxW-1:0];
          mem_re    = 1'b1;
        end else begin
          done_d       = 1'b1;
          rsp_d.status = (req_q.op == OP_LOOKUP) ? STAT_MISS : STAT_NOT_FOUND;
        end
      end

      S_CHECK: begin
        if (req_q.op == OP_LOOKUP) begin
          done_d = 1'b1;
          if (lookup_hit) begin
            rsp_d.status       = STAT_OK;
            rsp_d.hit          = 1'b1;
            rsp_d.found_handle = rdata_q.handle;
          end else begin
            rsp_d.status = STAT_MISS;
          end
        end else if (!handle_match) begin
          done_d       = 1'b1;
          rsp_d.status = STAT_NOT_FOUND;
        end else if (dn_start) begin
          mem_raddr = ptr_inc;
          mem_re    = 1'b1;
        end else begin
          // Last entry: drop it by shrinking the count
          cnt_d             = cnt_dec;
          done_d            = 1'b1;
          rsp_d.status      = STAT_OK;
          rsp_d.entry_count = CountW'(cnt_dec);
        end
      end

      S_SHIFT_UP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc;
        mem_wdata = rdata_q;
        if (up_more) begin
          ptr_d     = ptr_q - 1'b1;
          mem_raddr = ptr_q - 1'b1;
          mem_re    = 1'b1;
        end
      end

      S_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = rdata_q;
        if (dn_more) begin
          ptr_d     = ptr_inc;
          mem_raddr = ptr_inc + 1'b1;
          mem_re    = 1'b1;
        end else begin
          cnt_d             = cnt_dec;
          done_d            = 1'b1;
          rsp_d.status      = STAT_OK;
          rsp_d.entry_count = CountW'(cnt_dec);
        end
      end

      S_PLACE: begin
        mem_we            = 1'b1;
        mem_waddr         = ub_q[IdxW-1:0];
        mem_wdata.start   = req_q.addr;
        mem_wdata.stop    = end_q;
        mem_wdata.handle  = req_q.handle;
        cnt_d             = cnt_q + CntW'(1);
        done_d            = 1'b1;
        rsp_d.status      = STAT_OK;
        rsp_d.entry_count = CountW'(cnt_q + CntW'(1));
      end

      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= table_mem[mem_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      low_q   <= '1;
      high_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      low_q   <= low_d;
      high_q  <= high_d;
      done_q  <= done_d;
    end
  end

  // Working and response words
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    end_q <= end_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    ub_q  <= ub_d;
    ptr_q <= ptr_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
